### src/version_string_compare_top_defines.svh
`ifndef VERSION_STRING_COMPARE_TOP_DEFINES_SVH
`define VERSION_STRING_COMPARE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define VSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/vsc_pkg.sv
package vsc_pkg;

	localparam int QDepth = 4;
	localparam int QAddrW = $clog2(QDepth);
	localparam int QCountW = $clog2(QDepth + 1);

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_DIGIT = 2'd1,
		CLS_ZERO  = 2'd2
	} vsc_class_t;

	typedef enum logic [1:0] {
		S_NORMAL   = 2'd0,
		S_INTEGRAL = 2'd1,
		S_FRACTION = 2'd2,
		S_ZEROS    = 2'd3
	} vsc_scan_t;

	typedef enum logic [1:0] {
		PH_DONE = 2'd0,
		PH_SCAN = 2'd1,
		PH_LEN  = 2'd2
	} vsc_phase_t;

	typedef enum logic [1:0] {
		K_DIFF = 2'd0,
		K_LESS = 2'd1,
		K_MORE = 2'd2,
		K_LEN  = 2'd3
	} vsc_kind_t;

	typedef struct packed {
		logic             start;
		logic [1:0]       cls_a;
		logic [1:0]       cls_b;
		logic             a_nul;
		logic             dig_a;
		logic             dig_b;
		logic signed [8:0] diff;
	} vsc_item_t;

	localparam vsc_scan_t VSC_NEXT [16] = '{
		S_NORMAL,   S_INTEGRAL, S_ZEROS,    S_NORMAL,
		S_NORMAL,   S_INTEGRAL, S_INTEGRAL, S_INTEGRAL,
		S_NORMAL,   S_FRACTION, S_FRACTION, S_FRACTION,
		S_NORMAL,   S_FRACTION, S_ZEROS,    S_ZEROS
	};

	localparam vsc_kind_t VSC_DECIDE [64] = '{
		K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_LEN,  K_DIFF, K_DIFF,
		K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF,
		K_DIFF, K_LESS, K_LESS, K_DIFF, K_MORE, K_LEN,  K_LEN,  K_DIFF,
		K_MORE, K_LEN,  K_LEN,  K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF,
		K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_LEN,  K_DIFF, K_DIFF,
		K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF,
		K_DIFF, K_MORE, K_MORE, K_DIFF, K_LESS, K_DIFF, K_DIFF, K_DIFF,
		K_LESS, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF, K_DIFF
	};

	function automatic logic vsc_is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic [1:0] vsc_class(input logic [7:0] c);
		if (c == CHAR_ZERO) begin
			return CLS_ZERO;
		end else if (vsc_is_digit(c)) begin
			return CLS_DIGIT;
		end
		return CLS_OTHER;
	endfunction

endpackage

### src/version_string_compare_top.sv
// Version string compare: one character pair per item, one signed result per comparison.
// Front end: one item per cycle while the queue has room, via a classifier register.
// Back end: one queued pair per cycle unless a result is held waiting for result_ready.
// A four-entry queue sits between classifier and decision machine; result is registered.
// Reset (arst_n low, asynchronous): queue empty, no result pending, comparison decided.
module version_string_compare_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        char_a,
	input  logic [7:0]        char_b,
	input  logic              start_req,
	input  logic              item_valid,
	output logic              item_ready,
	output logic signed [8:0] result,
	output logic              result_valid,
	input  logic              result_ready
);
	import vsc_pkg::*;

	logic      push_valid;
	logic      push_ready;
	vsc_item_t push_item;
	logic      pop_valid;
	logic      pop_ready;
	vsc_item_t pop_item;

	vsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_a     (char_a),
		.char_b     (char_b),
		.start_req  (start_req),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	vsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	vsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

### src/vsc_front.sv
module vsc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         char_a,
	input  logic [7:0]         char_b,
	input  logic               start_req,
	input  logic               item_valid,
	output logic               item_ready,
	output logic               push_valid,
	input  logic               push_ready,
	output vsc_pkg::vsc_item_t push_item
);
	import vsc_pkg::*;

	logic      valid_s1;
	vsc_item_t item_s1;
	logic      accept;

	assign item_ready = !valid_s1 || push_ready;
	assign accept     = item_valid && item_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify on entry
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.start <= start_req;
			item_s1.cls_a <= vsc_class(char_a);
			item_s1.cls_b <= vsc_class(char_b);
			item_s1.a_nul <= (char_a == CHAR_NUL);
			item_s1.dig_a <= vsc_is_digit(char_a);
			item_s1.dig_b <= vsc_is_digit(char_b);
			item_s1.diff  <= $signed({1'b0, char_a}) - $signed({1'b0, char_b});
		end
	end

endmodule

### src/vsc_queue.sv
`include "version_string_compare_top_defines.svh"

module vsc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  vsc_pkg::vsc_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output vsc_pkg::vsc_item_t pop_item
);
	import vsc_pkg::*;

	vsc_item_t           slot_q [QDepth];
	logic [QAddrW-1:0]   wr_ptr_q;
	logic [QAddrW-1:0]   rd_ptr_q;
	logic [QCountW-1:0]  count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QCountW'(QDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	`VSC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= QCountW'(QDepth), "queue count overflow")
	`VSC_ASSERT_NOW(a_ptr_gap, 1'b1, (wr_ptr_q - rd_ptr_q) == count_q[QAddrW-1:0], "queue pointers disagree with count")

endmodule

### src/vsc_back.sv
`include "version_string_compare_top_defines.svh"

module vsc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  vsc_pkg::vsc_item_t pop_item,
	output logic signed [8:0]  result,
	output logic               result_valid,
	input  logic               result_ready
);
	import vsc_pkg::*;

	localparam logic signed [8:0] RES_LESS = -9'sd1;
	localparam logic signed [8:0] RES_MORE = 9'sd1;

	vsc_scan_t         scan_q, scan_d;
	vsc_phase_t        phase_q, phase_d;
	logic signed [8:0] saved_q, saved_d;
	logic signed [8:0] result_q, result_d;
	logic              out_valid_q;
	logic              pop;
	logic              emit;
	vsc_scan_t         scan_cur;
	vsc_phase_t        phase_cur;
	logic signed [8:0] saved_cur;
	vsc_kind_t         kind;

	assign pop_ready    = !out_valid_q || result_ready;
	assign pop          = pop_valid && pop_ready;
	assign result       = result_q;
	assign result_valid = out_valid_q;

	always_comb begin
		scan_cur  = pop_item.start ? S_NORMAL : scan_q;
		phase_cur = pop_item.start ? PH_SCAN  : phase_q;
		saved_cur = pop_item.start ? '0       : saved_q;
		kind      = VSC_DECIDE[{scan_cur, pop_item.cls_a, pop_item.cls_b}];
		scan_d    = scan_cur;
		phase_d   = phase_cur;
		saved_d   = saved_cur;
		emit      = 1'b0;
		result_d  = pop_item.diff;
		case (phase_cur)
			PH_SCAN: begin
				if (pop_item.diff == '0 && !pop_item.a_nul) begin
					scan_d = VSC_NEXT[{scan_cur, pop_item.cls_a}];
				end else begin
					case (kind)
						K_LESS: begin
							emit     = 1'b1;
							result_d = RES_LESS;
						end
						K_MORE: begin
							emit     = 1'b1;
							result_d = RES_MORE;
						end
						K_LEN: begin
							saved_d = pop_item.diff;
							phase_d = PH_LEN;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			PH_LEN: begin
				if (pop_item.dig_a) begin
					if (!pop_item.dig_b) begin
						emit     = 1'b1;
						result_d = RES_MORE;
					end
				end else begin
					emit     = 1'b1;
					result_d = pop_item.dig_b ? RES_LESS : saved_cur;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		if (emit) begin
			phase_d = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= S_NORMAL;
			phase_q     <= PH_DONE;
			saved_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				scan_q  <= scan_d;
				phase_q <= phase_d;
				saved_q <= saved_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			result_q <= result_d;
		end
	end

	`VSC_ASSERT_NEXT(a_emit_done, pop && emit, phase_q == PH_DONE && out_valid_q, "result without return to decided phase")
	`VSC_ASSERT_NOW(a_len_result, pop && emit && phase_cur == PH_LEN, result_d == RES_LESS || result_d == RES_MORE || result_d == saved_q, "bad result in length phase")

endmodule
